### design/rsa_be_pkg.sv
`timescale 1ns / 1ps

package rsa_be_pkg;

	// Field and register widths fixed by the block's interface
	localparam int BLOCK_W  = 16;
	localparam int CIPHER_W = 31;
	localparam int MOD_REG_W = 31;
	localparam int EXP_W    = 32;
	localparam int CFG_W    = 32;
	localparam int TDATA_IN_W  = 16;
	localparam int TDATA_OUT_W = 32;

	// Defaults for the top-level parameters
	localparam int BLOCK_BYTES_DEF  = 2;
	localparam int MODULUS_BITS_DEF = 31;

	// Register reset values
	localparam logic [MOD_REG_W-1:0] MOD_RESET = 31'd1;
	localparam logic [EXP_W-1:0]     EXP_RESET = 32'h0001_0001;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_MODULUS  = 1'b0,
		REG_EXPONENT = 1'b1
	} reg_idx_t;

	// Exponentiation sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MUL,
		ST_SQR,
		ST_OUT
	} state_t;

endpackage

### design/rsa_block_encrypt_unit.sv
`timescale 1ns / 1ps
// Each block takes one reduction (1 * block mod n) on the shared modmul, then
//   S = floor(log2 e) squarings and M = popcount(e) multiplies; e = 0 needs
//   only the reduction, and n = 0 bypasses the multiplier altogether.
// One block at a time: s_tready is high only while idle, and a result still
//   waiting in the output register holds the next block in its final state.
// Reset: arst_n async, active low; modulus resets to 1, exponent to 65537.

module rsa_block_encrypt_unit #(
	parameter int BLOCK_BYTES  = rsa_be_pkg::BLOCK_BYTES_DEF,
	parameter int MODULUS_BITS = rsa_be_pkg::MODULUS_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config write port
	input  logic                                 cfg_we,
	input  logic [0:0]                           cfg_idx,
	input  logic [rsa_be_pkg::CFG_W-1:0]         cfg_wdata,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [rsa_be_pkg::TDATA_IN_W-1:0]    s_tdata,   // [15:0] block
	// output stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [rsa_be_pkg::TDATA_OUT_W-1:0]   m_tdata    // [30:0] cipher, [31] zero
);

	// Block bits actually used and the shared multiplier operand width
	localparam int BLK_W = (8 * BLOCK_BYTES < rsa_be_pkg::BLOCK_W) ?
		8 * BLOCK_BYTES : rsa_be_pkg::BLOCK_W;
	localparam int MOD_W = MODULUS_BITS;
	localparam int OP_W  = (MOD_W > BLK_W) ? MOD_W : BLK_W;

	// ---------------- configuration registers ----------------
	logic [rsa_be_pkg::MOD_REG_W-1:0] modulus_q;
	logic [rsa_be_pkg::EXP_W-1:0]     exponent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= rsa_be_pkg::MOD_RESET;
			exponent_q <= rsa_be_pkg::EXP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				rsa_be_pkg::REG_MODULUS:  modulus_q  <= cfg_wdata[rsa_be_pkg::MOD_REG_W-1:0];
				rsa_be_pkg::REG_EXPONENT: exponent_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------- sequencer state ----------------
	rsa_be_pkg::state_t state_q, state_d;

	logic [rsa_be_pkg::EXP_W-1:0] e_q;      // remaining exponent bits
	logic [MOD_W-1:0]             n_q;
	logic [MOD_W-1:0]             acc_q;
	logic [MOD_W-1:0]             base_q;
	logic                         out_vld_q;
	logic [rsa_be_pkg::CIPHER_W-1:0] cipher_q;

	logic             accept;
	logic             out_load;
	logic             mm_start;
	logic             mm_done;
	logic [MOD_W-1:0] mm_res;
	logic [MOD_W-1:0] mm_a;
	logic [OP_W-1:0]  mm_b;
	logic [MOD_W-1:0] mm_n;
	logic [MOD_W-1:0] n_in;
	logic [MOD_W-1:0] base_n;
	logic [MOD_W-1:0] acc_n;
	logic [OP_W-1:0]  block_in;

	assign n_in     = modulus_q[MOD_W-1:0];
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == rsa_be_pkg::ST_OUT) && (!out_vld_q || m_tready);

	// block reduction: 1 * block mod n, block taken straight off the bus
	assign block_in = OP_W'(s_tdata[BLK_W-1:0]);

	// modulus is latched at accept; the reduce start takes n_in directly, before n_q holds it
	assign mm_n = accept ? n_in : n_q;

	// Bypass the multiplier result so back-to-back ops see fresh operands
	assign base_n = (mm_done && (state_q == rsa_be_pkg::ST_REDUCE ||
		state_q == rsa_be_pkg::ST_SQR)) ? mm_res : base_q;
	assign acc_n  = (mm_done && state_q == rsa_be_pkg::ST_MUL) ? mm_res : acc_q;

	// next state: right-to-left square-and-multiply, stop once e runs out
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsa_be_pkg::ST_IDLE: begin
				if (accept)
					state_d = (n_in == '0) ? rsa_be_pkg::ST_OUT : rsa_be_pkg::ST_REDUCE;
			end
			rsa_be_pkg::ST_REDUCE: begin
				if (mm_done) begin
					if (e_q == '0)
						state_d = rsa_be_pkg::ST_OUT;
					else if (e_q[0])
						state_d = rsa_be_pkg::ST_MUL;
					else
						state_d = rsa_be_pkg::ST_SQR;
				end
			end
			rsa_be_pkg::ST_MUL: begin
				if (mm_done)
					state_d = (e_q[rsa_be_pkg::EXP_W-1:1] == '0) ?
						rsa_be_pkg::ST_OUT : rsa_be_pkg::ST_SQR;
			end
			rsa_be_pkg::ST_SQR: begin
				// e_q shifts at this edge; bit 1 is the next bit to use
				if (mm_done)
					state_d = e_q[1] ? rsa_be_pkg::ST_MUL : rsa_be_pkg::ST_SQR;
			end
			rsa_be_pkg::ST_OUT: begin
				if (out_load)
					state_d = rsa_be_pkg::ST_IDLE;
			end
			default: state_d = rsa_be_pkg::ST_IDLE;
		endcase
	end

	// outputs: kick the shared unit on every entry into a compute state
	always_comb begin
		s_tready = (state_q == rsa_be_pkg::ST_IDLE);
		mm_start = 1'b0;
		mm_a     = base_n;
		mm_b     = OP_W'(base_n);
		unique case (state_d)
			rsa_be_pkg::ST_REDUCE: begin
				mm_start = accept;
				mm_a     = MOD_W'(1);
				mm_b     = block_in;
			end
			rsa_be_pkg::ST_MUL: begin
				mm_start = mm_done;
				mm_a     = acc_n;
				mm_b     = OP_W'(base_n);
			end
			rsa_be_pkg::ST_SQR: begin
				mm_start = mm_done;
				mm_a     = base_n;
				mm_b     = OP_W'(base_n);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rsa_be_pkg::ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			e_q     <= exponent_q;
			n_q     <= n_in;
			// 1 mod n; n of 0 or 1 gives 0
			acc_q   <= (n_in[MOD_W-1:1] == '0) ? '0 : MOD_W'(1);
		end else begin
			base_q <= base_n;
			acc_q  <= acc_n;
			if (mm_done && state_q == rsa_be_pkg::ST_SQR)
				e_q <= e_q >> 1;
		end
		if (out_load)
			cipher_q <= rsa_be_pkg::CIPHER_W'(acc_q);
	end

	rsa_be_modmul #(
		.MOD_W (MOD_W),
		.OP_W  (OP_W)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.n      (mm_n),
		.done   (mm_done),
		.res    (mm_res)
	);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, cipher_q};

endmodule

### design/rsa_be_modmul.sv
`timescale 1ns / 1ps

// Bit-serial interleaved modular multiply: res = (a * b) mod n.
// Requires a <= n and n >= 1. One multiplier bit per cycle, MSB first.
module rsa_be_modmul #(
	parameter int MOD_W = rsa_be_pkg::MODULUS_BITS_DEF,
	parameter int OP_W  = rsa_be_pkg::MODULUS_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MOD_W-1:0] a,
	input  logic [OP_W-1:0]  b,
	input  logic [MOD_W-1:0] n,
	output logic             done,
	output logic [MOD_W-1:0] res
);

	localparam int CNT_W = $clog2(OP_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OP_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MOD_W-1:0] r_q;
	logic [MOD_W-1:0] a_q;
	logic [MOD_W-1:0] n_q;
	logic [OP_W-1:0]  b_q;

	logic [MOD_W:0] dbl;
	logic [MOD_W:0] dbl_red;
	logic [MOD_W:0] sum;
	logic [MOD_W:0] sum_red;
	logic [MOD_W:0] n_ext;

	// r <- (2r mod n + bit*a) mod n; each partial stays below 2n
	always_comb begin
		n_ext   = {1'b0, n_q};
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
		sum     = dbl_red + (b_q[OP_W-1] ? {1'b0, a_q} : '0);
		sum_red = (sum >= n_ext) ? (sum - n_ext) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			r_q <= '0;
			a_q <= a;
			b_q <= b;
			n_q <= n;
		end else if (busy_q) begin
			r_q <= sum_red[MOD_W-1:0];
			b_q <= {b_q[OP_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res  = r_q;

endmodule

### design/rsa_be_checker.sv
`timescale 1ns / 1ps

module rsa_be_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one block at a time: busy right after taking a beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// a new result only comes out of a busy period
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a block in flight");

	// pad bit above cipher stays clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31] == 1'b0)
		else $error("cipher pad bit set");

endmodule

bind rsa_block_encrypt_unit rsa_be_checker u_rsa_be_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### test/tb_rsa_block_encrypt_unit.sv
`timescale 1ns / 1ps

module tb_rsa_block_encrypt_unit;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 11;
	// Worst correct run: e = 2^32-1 costs 64 modmuls, plus the long receiver
	// hold and the longest sender gap; taken several times over.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RX_HOLD_CYCLES = 3000;
	// Slowest block (full 32-bit exponent) plus margin, to catch late beats
	localparam int DRAIN_CYCLES   = 2200;
	localparam int SETTLE_CYCLES  = 4;
	localparam int RANDOM_ITEMS   = 520;

	// Receiver stall styles
	localparam int RX_ALWAYS   = 0;
	localparam int RX_RANDOM   = 1;
	localparam int RX_PERIODIC = 2;
	localparam int RX_SPARSE   = 3;

	logic                                   clk       = 1'b0;
	logic                                   arst_n    = 1'b0;
	logic                                   cfg_we    = 1'b0;
	logic [0:0]                             cfg_idx   = rsa_be_pkg::REG_MODULUS;
	logic [rsa_be_pkg::CFG_W-1:0]           cfg_wdata = '0;
	logic                                   s_tvalid  = 1'b0;
	logic                                   s_tready;
	logic [rsa_be_pkg::TDATA_IN_W-1:0]      s_tdata   = '0;   // [15:0] block
	logic                                   m_tvalid;
	logic                                   m_tready  = 1'b0;
	logic [rsa_be_pkg::TDATA_OUT_W-1:0]     m_tdata;          // [30:0] cipher, [31] zero

	// Shadow of the key registers, reset values as in the block
	logic [rsa_be_pkg::MOD_REG_W-1:0] key_modulus  = rsa_be_pkg::MOD_RESET;
	logic [rsa_be_pkg::EXP_W-1:0]     key_exponent = rsa_be_pkg::EXP_RESET;

	// Expected ciphers, oldest first
	logic [rsa_be_pkg::CIPHER_W-1:0]  cipher_q[$];

	int  err_cnt     = 0;
	int  idle_cycles = 0;
	int  burst_left  = 0;
	bit  gaps_on     = 1'b1;
	bit  rx_hold_req = 1'b0;

	always #CLK_HALF clk = ~clk;

	rsa_block_encrypt_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// block^e mod n, right-to-left square-and-multiply in 64 bits.
	// n < 2^31, so every product fits. n == 0 gives 0 by definition.
	function automatic logic [rsa_be_pkg::CIPHER_W-1:0] rsa_power(
		input logic [rsa_be_pkg::BLOCK_W-1:0] blk);
		logic [63:0] n;
		logic [63:0] acc;
		logic [63:0] base;
		logic [rsa_be_pkg::EXP_W-1:0] e;
		n = {33'd0, key_modulus};
		if (n == 64'd0)
			return '0;
		acc  = 64'd1 % n;
		base = {48'd0, blk} % n;
		e    = key_exponent;
		while (e != '0) begin
			if (e[0])
				acc = (acc * base) % n;
			base = (base * base) % n;
			e    = e >> 1;
		end
		return acc[rsa_be_pkg::CIPHER_W-1:0];
	endfunction

	// Drop valid and hold off until every expected cipher has come back.
	// Always waits on the clock before it returns, so a following valid or write
	// lands in a later time step.
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (cipher_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Key writes only happen with the block idle
	task automatic write_reg(input rsa_be_pkg::reg_idx_t idx,
		input logic [rsa_be_pkg::CFG_W-1:0] value);
		wait_drain();
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == rsa_be_pkg::REG_MODULUS)
			key_modulus = value[rsa_be_pkg::MOD_REG_W-1:0];
		else
			key_exponent = value;
	endtask

	task automatic load_key(input logic [rsa_be_pkg::CFG_W-1:0] n_word,
		input logic [rsa_be_pkg::CFG_W-1:0] e_word);
		write_reg(rsa_be_pkg::REG_MODULUS, n_word);
		write_reg(rsa_be_pkg::REG_EXPONENT, e_word);
	endtask

	// Offer one block, wait for the beat, queue its cipher. At the end of a
	// burst valid may drop for a random gap; inside a burst it stays high.
	task automatic send_block(input logic [rsa_be_pkg::BLOCK_W-1:0] blk);
		int gap;
		s_tdata  <= blk;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		cipher_q.push_back(rsa_power(blk));
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0 && gaps_on) begin
			burst_left = $urandom_range(1, 12);
			case ($urandom_range(0, 7))
				0, 1: gap = 0;
				7: gap = $urandom_range(100, 700);
				default: gap = $urandom_range(1, 30);
			endcase
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				// junk while idle, must be ignored
				s_tdata  <= rsa_be_pkg::TDATA_IN_W'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Receiver: changes stall style at random intervals; on request it
	// holds off for a long stretch so the input side backs up.
	initial begin : rx_side
		int style;
		int style_left;
		int tick;
		style      = RX_ALWAYS;
		style_left = 0;
		tick       = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				if (style_left == 0) begin
					style      = $urandom_range(RX_ALWAYS, RX_SPARSE);
					style_left = $urandom_range(50, 600);
				end
				style_left--;
				case (style)
					RX_ALWAYS:   m_tready <= 1'b1;
					RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
					RX_PERIODIC: m_tready <= ((tick % 11) >= 6);
					default:     m_tready <= ($urandom_range(0, 9) == 0);
				endcase
			end
		end
	end

	// Result check: every output beat against the oldest expectation
	always @(posedge clk) begin : cipher_check
		logic [rsa_be_pkg::CIPHER_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (cipher_q.size() == 0) begin
				$error("cipher: expected none, actual %0d",
					m_tdata[rsa_be_pkg::CIPHER_W-1:0]);
				err_cnt++;
			end else begin
				want = cipher_q.pop_front();
				if (m_tdata[rsa_be_pkg::CIPHER_W-1:0] !== want) begin
					$error("cipher: expected %0d, actual %0d", want,
						m_tdata[rsa_be_pkg::CIPHER_W-1:0]);
					err_cnt++;
				end
				if (m_tdata[rsa_be_pkg::TDATA_OUT_W-1:rsa_be_pkg::CIPHER_W] !== '0) begin
					$error("tdata pad: expected 0, actual %0b",
						m_tdata[rsa_be_pkg::TDATA_OUT_W-1:rsa_be_pkg::CIPHER_W]);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog: too long without any beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$error("watchdog: no beat for %0d cycles, %0d ciphers pending",
				idle_cycles, cipher_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Reset values: modulus 1 makes every cipher 0; then a real modulus with
	// the exponent left at its reset value of 65537.
	task automatic test_reset_values();
		send_block(16'h1234);
		send_block(16'hFFFF);
		write_reg(rsa_be_pkg::REG_MODULUS, 32'h7FFF_FFFF);
		send_block(16'hFFFF);
		send_block(16'h0002);
	endtask

	// Extreme and single-bit blocks under the largest modulus
	task automatic test_edge_blocks();
		load_key(32'h7FFF_FFFF, 32'h0001_0001);
		send_block(16'h0000);
		send_block(16'h0001);
		send_block(16'h8000);
		send_block(16'h00FF);
		send_block(16'hFF00);
		send_block(16'h5AA5);
	endtask

	// Exponent zero, modulus one, modulus zero (written with only the
	// dropped top bit set)
	task automatic test_degenerate_keys();
		write_reg(rsa_be_pkg::REG_EXPONENT, 32'h0000_0000);
		send_block(16'h1234);
		send_block(16'h0000);          // 0^0 gives 1
		write_reg(rsa_be_pkg::REG_MODULUS, 32'h0000_0001);
		send_block(16'hBEEF);
		write_reg(rsa_be_pkg::REG_EXPONENT, 32'h0001_0001);
		send_block(16'hBEEF);
		write_reg(rsa_be_pkg::REG_MODULUS, 32'h8000_0000);
		send_block(16'h4321);
	endtask

	// Base above the modulus gets reduced first; full 32-bit exponent
	task automatic test_base_reduction();
		load_key(32'd251, 32'd1);
		send_block(16'hFFFF);
		send_block(16'd250);
		send_block(16'd251);
		load_key(32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_block(16'hFFFF);
		send_block(16'h0003);
	endtask

	// Long receiver hold with a steady sender, then a full pause mid-stream
	task automatic test_backpressure();
		int k;
		load_key(32'd65521, 32'd3);    // short exponent, block fills quickly
		gaps_on     = 1'b0;
		rx_hold_req = 1'b1;
		for (k = 0; k < 10; k++)
			send_block(rsa_be_pkg::BLOCK_W'($urandom));
		wait_drain();
		for (k = 0; k < 3; k++)
			send_block(rsa_be_pkg::BLOCK_W'($urandom));
		wait_drain();
		gaps_on = 1'b1;
		for (k = 0; k < 3; k++)
			send_block(rsa_be_pkg::BLOCK_W'($urandom));
	endtask

	// Random keys per phase, random blocks within it
	task automatic test_random_keys();
		int sent;
		int k;
		int n_items;
		logic [rsa_be_pkg::CFG_W-1:0] n_word;
		logic [rsa_be_pkg::CFG_W-1:0] e_word;
		logic [rsa_be_pkg::BLOCK_W-1:0] blk;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       n_word = $urandom_range(2, 255);
				1:       n_word = $urandom_range(256, 65535);
				2, 3, 4: n_word = $urandom | 32'h4000_0000;   // full 31-bit modulus
				8:       n_word = 32'd1;
				9:       n_word = ($urandom_range(0, 3) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				default: n_word = $urandom;                   // top bit is dropped
			endcase
			// Mostly short exponents keep the run fast; a few full-width ones
			case ($urandom_range(0, 9))
				0, 1, 2, 3: e_word = $urandom_range(0, 255);
				4, 5:       e_word = 32'h0001_0001;
				6, 7:       e_word = $urandom & 32'h0001_FFFF;
				8:          e_word = $urandom & 32'h00FF_FFFF;
				default:    e_word = $urandom;
			endcase
			load_key(n_word, e_word);
			n_items = $urandom_range(20, 60);
			for (k = 0; k < n_items && sent < RANDOM_ITEMS; k++) begin
				case ($urandom_range(0, 15))
					0:       blk = 16'h0000;
					1:       blk = 16'hFFFF;
					2:       blk = 16'h0001;
					default: blk = rsa_be_pkg::BLOCK_W'($urandom);
				endcase
				send_block(blk);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_edge_blocks();
		test_degenerate_keys();
		test_base_reduction();
		test_backpressure();
		test_random_keys();

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (cipher_q.size() != 0) begin
			$error("cipher: %0d expected beats never arrived", cipher_q.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
